[hdl/hpl_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hpl_pkg
// Shared types, constants and functions for the Hamming pattern link checker:
// Hamming (12,8) check bit equations, the syndrome-to-bit flip table, the
// lane shifts of the expected-pattern table and the register map.
// ----------------------------------------------------------------------------
package hpl_pkg;

    localparam int DATA_W     = 8;
    localparam int CHECK_W    = 4;
    localparam int WORD_W     = 16;
    localparam int OUT_CNT_W  = 24;
    localparam int CFG_DATA_W = 32;
    localparam int CFG_ADDR_W = 4;
    localparam int LANES      = 8;

    // Syndromes above this value cannot come from a single error.
    localparam logic [CHECK_W-1:0] SYN_MAX_SINGLE = 4'd12;

    // Bit positions in the captured link word.
    localparam int LOW_DATA_LSB  = 2;
    localparam int LOW_DATA_W    = 6;
    localparam int HIGH_DATA_LSB = 10;
    localparam int HIGH_DATA_W   = 2;
    localparam int CHECK_LSB     = 12;

    // Register indexes (byte address bits 3..2).
    typedef enum logic [1:0] {
        REG_PATTERN_WORD      = 2'd0,
        REG_WRAP_PHASE        = 2'd1,
        REG_WRAP_CHECK_ENABLE = 2'd2,
        REG_UNUSED            = 2'd3
    } reg_index_t;

    localparam logic [31:0] PATTERN_WORD_RESET      = 32'h135E_26BC;
    localparam logic [3:0]  WRAP_PHASE_RESET        = 4'd1;
    localparam logic        WRAP_CHECK_ENABLE_RESET = 1'b1;

    // Position offset of each output lane into the pattern word.
    localparam logic [4:0] LANE_SHIFT [LANES] = '{
        5'd0, 5'd4, 5'd8, 5'd0, 5'd14, 5'd2, 5'd2, 5'd3
    };

    // Syndrome to (data bit + 1); zero means no data bit to flip.
    localparam logic [3:0] FLIP [16] = '{
        4'd0, 4'd0, 4'd0, 4'd1, 4'd0, 4'd2, 4'd3, 4'd4,
        4'd0, 4'd5, 4'd6, 4'd7, 4'd8, 4'd0, 4'd0, 4'd0
    };

    typedef struct packed {
        logic [DATA_W-1:0]  data;
        logic [CHECK_W-1:0] chk;
        logic [CHECK_W-1:0] comp;
        logic [DATA_W-1:0]  corr;
        logic               perr;
        logic               uncorr;
    } decode_t;

    typedef struct packed {
        logic [DATA_W-1:0]    data_received;
        logic [CHECK_W-1:0]   check_received;
        logic [CHECK_W-1:0]   check_computed;
        logic [DATA_W-1:0]    data_corrected;
        logic                 parity_error;
        logic                 uncorrectable;
        logic                 unexpected;
        logic [DATA_W-1:0]    expected_data;
        logic                 locked;
        logic [OUT_CNT_W-1:0] parity_error_total;
        logic [OUT_CNT_W-1:0] unexpected_total;
        logic [OUT_CNT_W-1:0] wrap_total;
    } result_t;

    function automatic logic [CHECK_W-1:0] hamming_of(input logic [DATA_W-1:0] d);
        logic [CHECK_W-1:0] p;
        p[0] = d[0] ^ d[1] ^ d[3] ^ d[4] ^ d[6];
        p[1] = d[0] ^ d[2] ^ d[3] ^ d[5] ^ d[6];
        p[2] = d[1] ^ d[2] ^ d[3] ^ d[7];
        p[3] = d[4] ^ d[5] ^ d[6] ^ d[7];
        return p;
    endfunction

    // Lane c of pattern idx is pattern word bit 31 - (LANE_SHIFT[c] + idx).
    function automatic logic [DATA_W-1:0] pattern_at(input logic [31:0] word,
                                                     input logic [4:0]  idx);
        logic [DATA_W-1:0] v;
        logic [4:0]        pos;
        v = '0;
        for (int c = 0; c < LANES; c++) begin
            pos  = LANE_SHIFT[c] + idx;
            v[c] = word[5'd31 - pos];
        end
        return v;
    endfunction

endpackage

[hdl/hpl_decode.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hpl_decode
// Unpacks a link word into data and check bits, recomputes the Hamming check
// bits and corrects a single data-bit error from the syndrome.
// ----------------------------------------------------------------------------
module hpl_decode (
    input  logic [hpl_pkg::WORD_W-1:0] link_word,
    output hpl_pkg::decode_t           dec
);

    logic [hpl_pkg::DATA_W-1:0]  data;
    logic [hpl_pkg::CHECK_W-1:0] chk;
    logic [hpl_pkg::CHECK_W-1:0] comp;
    logic [hpl_pkg::CHECK_W-1:0] syn;
    logic [hpl_pkg::CHECK_W-1:0] flip;
    logic                        uncorr;
    logic [hpl_pkg::DATA_W-1:0]  flip_mask;

    assign data = {link_word[hpl_pkg::HIGH_DATA_LSB +: hpl_pkg::HIGH_DATA_W],
                   link_word[hpl_pkg::LOW_DATA_LSB  +: hpl_pkg::LOW_DATA_W]};
    assign chk  = link_word[hpl_pkg::CHECK_LSB +: hpl_pkg::CHECK_W];
    assign comp = hpl_pkg::hamming_of(data);
    assign syn  = chk ^ comp;
    assign flip = hpl_pkg::FLIP[syn];

    assign uncorr    = (syn > hpl_pkg::SYN_MAX_SINGLE);
    // flip holds the data bit plus one; zero leaves the data alone
    assign flip_mask = (uncorr || flip == '0) ? '0
                     : (hpl_pkg::DATA_W'(1) << (flip - 4'd1));

    always_comb
    begin
        dec.data   = data;
        dec.chk    = chk;
        dec.comp   = comp;
        dec.corr   = data ^ flip_mask;
        dec.perr   = (syn != '0);
        dec.uncorr = uncorr;
    end

endmodule

[hdl/hamming_pattern_link_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hamming_pattern_link_checker
// Hamming (12,8) link word decoder with test-pattern lock, prediction and
// saturating error, mismatch and wrap counters.
// ----------------------------------------------------------------------------
// Each request carries one captured 16-bit link word and yields exactly one
// result. An input register holds the word. A single pass of decode, pattern
// search and prediction logic runs between it and the result register. The
// tracking state advances as the word moves into the result register. The block
// takes one request every clock cycle while the result is not stalled. out_valid
// rises when the word moves from the input register into the result register. A
// stalled result holds the input register, which then raises in_stall. The
// expected-pattern table is formed from pattern_word on the fly. While searching,
// a parity-clean word is located at the first table entry that equals it.
// LOCK_RUN consecutive in-sequence words set the lock, which only reset clears.
// Once locked, every word that is not uncorrectable is compared with the
// predicted pattern. A word equal to pattern zero, but not to the predicted
// pattern, at the predicted index wrap_phase restarts the sequence when
// wrap_check_enable is set. Counters stop at their full value. Write the
// registers over the APB port only while no request is in flight.
// ----------------------------------------------------------------------------
module hamming_pattern_link_checker #(
    parameter int PATTERN_COUNT = 15,
    parameter int LOCK_RUN      = 5,
    parameter int COUNTER_BITS  = 24
) (
    input  logic                                clk,
    input  logic                                rst_n,

    // configuration port
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [hpl_pkg::CFG_ADDR_W-1:0]      paddr,
    input  logic [hpl_pkg::CFG_DATA_W-1:0]      pwdata,
    output logic [hpl_pkg::CFG_DATA_W-1:0]      prdata,
    output logic                                pready,

    // request channel
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [hpl_pkg::WORD_W-1:0]          link_word,

    // result channel
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [hpl_pkg::DATA_W-1:0]          data_received,
    output logic [hpl_pkg::CHECK_W-1:0]         check_received,
    output logic [hpl_pkg::CHECK_W-1:0]         check_computed,
    output logic [hpl_pkg::DATA_W-1:0]          data_corrected,
    output logic                                parity_error,
    output logic                                uncorrectable,
    output logic                                unexpected,
    output logic [hpl_pkg::DATA_W-1:0]          expected_data,
    output logic                                locked,
    output logic [hpl_pkg::OUT_CNT_W-1:0]       parity_error_total,
    output logic [hpl_pkg::OUT_CNT_W-1:0]       unexpected_total,
    output logic [hpl_pkg::OUT_CNT_W-1:0]       wrap_total
);

    localparam int IDX_W = $clog2(PATTERN_COUNT);
    localparam int RUN_W = $clog2(LOCK_RUN + 1);
    localparam int CMP_W = (IDX_W > 4) ? IDX_W : 4;

    typedef logic [IDX_W-1:0]        idx_t;
    typedef logic [COUNTER_BITS-1:0] cnt_t;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [31:0] pattern_word_reg;
    logic [3:0]  wrap_phase_reg;
    logic        wrap_check_enable_reg;
    logic        cfg_write;
    hpl_pkg::reg_index_t cfg_sel;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign cfg_sel   = hpl_pkg::reg_index_t'(paddr[3:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_word_reg      <= hpl_pkg::PATTERN_WORD_RESET;
            wrap_phase_reg        <= hpl_pkg::WRAP_PHASE_RESET;
            wrap_check_enable_reg <= hpl_pkg::WRAP_CHECK_ENABLE_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_sel)
                hpl_pkg::REG_PATTERN_WORD:      pattern_word_reg      <= pwdata;
                hpl_pkg::REG_WRAP_PHASE:        wrap_phase_reg        <= pwdata[3:0];
                hpl_pkg::REG_WRAP_CHECK_ENABLE: wrap_check_enable_reg <= pwdata[0];
                default:                        ;  // no register here: drop
            endcase
        end
    end

    // Read back the addressed register; an empty slot reads as zero.
    always_comb
    begin
        unique case (cfg_sel)
            hpl_pkg::REG_PATTERN_WORD:      prdata = pattern_word_reg;
            hpl_pkg::REG_WRAP_PHASE:        prdata = {28'd0, wrap_phase_reg};
            hpl_pkg::REG_WRAP_CHECK_ENABLE: prdata = {31'd0, wrap_check_enable_reg};
            default:                        prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Handshake: input register, then result register
    // ------------------------------------------------------------------
    logic                        s1_valid_reg, s1_valid_next;
    logic [hpl_pkg::WORD_W-1:0]  s1_word_reg;
    logic                        out_valid_reg, out_valid_next;
    hpl_pkg::result_t            out_reg, out_next;
    logic                        out_free;
    logic                        in_take;
    logic                        advance;

    // The result slot frees up when it is empty or being taken this cycle.
    assign out_free = !out_valid_reg || !out_stall;
    assign advance  = s1_valid_reg && out_free;
    assign in_stall = s1_valid_reg && !out_free;
    assign in_take  = in_valid && !in_stall;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (in_take)
            s1_valid_next = 1'b1;
        else if (advance)
            s1_valid_next = 1'b0;

        out_valid_next = out_valid_reg;
        if (advance)
            out_valid_next = 1'b1;
        else if (!out_stall)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
            s1_word_reg <= link_word;
        if (advance)
            out_reg <= out_next;
    end

    // ------------------------------------------------------------------
    // Decode
    // ------------------------------------------------------------------
    hpl_pkg::decode_t dec;

    hpl_decode u_decode (
        .link_word (s1_word_reg),
        .dec       (dec)
    );

    // ------------------------------------------------------------------
    // Expected-pattern table and first-match search
    // ------------------------------------------------------------------
    logic [hpl_pkg::DATA_W-1:0] pat [PATTERN_COUNT];
    logic                       find_hit;
    idx_t                       find_idx;

    always_comb
    begin
        for (int i = 0; i < PATTERN_COUNT; i++)
            pat[i] = hpl_pkg::pattern_at(pattern_word_reg, 5'(i));
    end

    // Walk from the top so the lowest matching entry wins.
    always_comb
    begin
        find_hit = 1'b0;
        find_idx = '0;
        for (int i = PATTERN_COUNT - 1; i >= 0; i--)
        begin
            if (pat[i] == dec.data)
            begin
                find_hit = 1'b1;
                find_idx = IDX_W'(i);
            end
        end
    end

    // ------------------------------------------------------------------
    // Tracking state
    // ------------------------------------------------------------------
    idx_t                 pattern_index_reg, pattern_index_next;
    logic [RUN_W-1:0]     run_length_reg, run_length_next;
    logic                 lock_reg, lock_next;
    cnt_t                 parity_cnt_reg, parity_cnt_next;
    cnt_t                 unexp_cnt_reg, unexp_cnt_next;
    cnt_t                 wrap_cnt_reg, wrap_cnt_next;

    idx_t                       idx_succ;
    idx_t                       pred_idx;
    idx_t                       search_idx;
    logic                       wrap_hit;
    logic                       unexp;
    logic [hpl_pkg::DATA_W-1:0] expd;
    logic                       search_hit;

    function automatic idx_t idx_inc(input idx_t i);
        return (i == IDX_W'(PATTERN_COUNT - 1)) ? '0 : i + 1'b1;
    endfunction

    function automatic cnt_t sat_inc(input cnt_t c);
        return (c == '1) ? c : c + 1'b1;
    endfunction

    assign idx_succ = idx_inc(pattern_index_reg);

    // Locked path: accept a restart to pattern zero at the wrap phase.
    assign wrap_hit = wrap_check_enable_reg
                   && dec.data != pat[pattern_index_reg]
                   && dec.data == pat[0]
                   && CMP_W'(pattern_index_reg) == CMP_W'(wrap_phase_reg);
    assign pred_idx = wrap_hit ? '0 : pattern_index_reg;
    assign expd     = pat[pred_idx];

    always_comb
    begin
        priority if (!dec.perr)
            unexp = (dec.data != expd);
        else if (!dec.uncorr)
            unexp = (dec.corr != expd);
        else
            unexp = 1'b0;
    end

    always_comb
    begin
        pattern_index_next = pattern_index_reg;
        run_length_next    = run_length_reg;
        lock_next          = lock_reg;
        parity_cnt_next    = parity_cnt_reg;
        unexp_cnt_next     = unexp_cnt_reg;
        wrap_cnt_next      = wrap_cnt_reg;
        search_hit         = 1'b0;
        search_idx         = pattern_index_reg;

        priority if (lock_reg)
        begin
            if (wrap_hit)
                wrap_cnt_next = sat_inc(wrap_cnt_reg);
            if (dec.perr)
                parity_cnt_next = sat_inc(parity_cnt_reg);
            if (unexp)
                unexp_cnt_next = sat_inc(unexp_cnt_reg);
            pattern_index_next = idx_inc(pred_idx);
        end
        else if (dec.perr)
        begin
            run_length_next = '0;
        end
        else
        begin
            if (run_length_reg == '0)
            begin
                // Start a run at the first matching entry.
                if (find_hit)
                begin
                    search_idx      = find_idx;
                    run_length_next = RUN_W'(1);
                    search_hit      = 1'b1;
                end
            end
            else
            begin
                // Continue only if the word sits at the next entry.
                search_idx = idx_succ;
                if (find_hit && find_idx == idx_succ)
                begin
                    run_length_next = run_length_reg + 1'b1;
                    search_hit      = 1'b1;
                end
                else
                begin
                    run_length_next = '0;
                end
            end

            if (search_hit && run_length_next == RUN_W'(LOCK_RUN))
            begin
                lock_next          = 1'b1;
                pattern_index_next = idx_inc(search_idx);
            end
            else
            begin
                pattern_index_next = search_idx;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_index_reg <= '0;
            run_length_reg    <= '0;
            lock_reg          <= 1'b0;
            parity_cnt_reg    <= '0;
            unexp_cnt_reg     <= '0;
            wrap_cnt_reg      <= '0;
        end
        else if (advance)
        begin
            pattern_index_reg <= pattern_index_next;
            run_length_reg    <= run_length_next;
            lock_reg          <= lock_next;
            parity_cnt_reg    <= parity_cnt_next;
            unexp_cnt_reg     <= unexp_cnt_next;
            wrap_cnt_reg      <= wrap_cnt_next;
        end
    end

    // ------------------------------------------------------------------
    // Result assembly: only words checked under lock report a prediction
    // ------------------------------------------------------------------
    always_comb
    begin
        out_next.data_received      = dec.data;
        out_next.check_received     = dec.chk;
        out_next.check_computed     = dec.comp;
        out_next.data_corrected     = dec.corr;
        out_next.parity_error       = dec.perr;
        out_next.uncorrectable      = dec.uncorr;
        out_next.unexpected         = lock_reg && unexp;
        out_next.expected_data      = lock_reg ? expd : '0;
        out_next.locked             = lock_next;
        out_next.parity_error_total = hpl_pkg::OUT_CNT_W'(parity_cnt_next);
        out_next.unexpected_total   = hpl_pkg::OUT_CNT_W'(unexp_cnt_next);
        out_next.wrap_total         = hpl_pkg::OUT_CNT_W'(wrap_cnt_next);
    end

    assign out_valid          = out_valid_reg;
    assign data_received      = out_reg.data_received;
    assign check_received     = out_reg.check_received;
    assign check_computed     = out_reg.check_computed;
    assign data_corrected     = out_reg.data_corrected;
    assign parity_error       = out_reg.parity_error;
    assign uncorrectable      = out_reg.uncorrectable;
    assign unexpected         = out_reg.unexpected;
    assign expected_data      = out_reg.expected_data;
    assign locked             = out_reg.locked;
    assign parity_error_total = out_reg.parity_error_total;
    assign unexpected_total   = out_reg.unexpected_total;
    assign wrap_total         = out_reg.wrap_total;

endmodule

[hdl/hpl_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hpl_checker
// Port-level checks of the Hamming pattern link checker, bound to the top.
// ----------------------------------------------------------------------------
module hpl_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            out_valid,
    input logic                            out_stall,
    input logic [hpl_pkg::DATA_W-1:0]      data_received,
    input logic [hpl_pkg::CHECK_W-1:0]     check_received,
    input logic [hpl_pkg::CHECK_W-1:0]     check_computed,
    input logic [hpl_pkg::DATA_W-1:0]      data_corrected,
    input logic                            parity_error,
    input logic                            uncorrectable,
    input logic                            unexpected,
    input logic [hpl_pkg::DATA_W-1:0]      expected_data,
    input logic                            locked
);

    // A stalled result stays on offer.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result dropped while stalled");

    // A clean word is never altered by correction.
    a_clean_word: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !parity_error |->
            data_corrected == data_received && check_received == check_computed)
        else $error("clean word changed");

    // A multi-bit error implies a parity error and is never counted as a mismatch.
    a_uncorr: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && uncorrectable |->
            parity_error && !unexpected && data_corrected == data_received)
        else $error("uncorrectable word handled wrongly");

    // No prediction is reported before lock.
    a_no_pred_unlocked: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !locked |-> !unexpected && expected_data == '0)
        else $error("prediction reported while searching");

endmodule

bind hamming_pattern_link_checker hpl_checker u_hpl_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .data_received  (data_received),
    .check_received (check_received),
    .check_computed (check_computed),
    .data_corrected (data_corrected),
    .parity_error   (parity_error),
    .uncorrectable  (uncorrectable),
    .unexpected     (unexpected),
    .expected_data  (expected_data),
    .locked         (locked)
);
